FILE: rtl/hbc_pkg.sv
// Shared types and constants of the histogram bin counter.
`default_nettype none

package hbc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_RANGE_START = 2'd0;
    localparam logic [1:0] REG_RANGE_STOP  = 2'd1;
    localparam logic [1:0] REG_BIN_STEP    = 2'd2;
    localparam logic [1:0] REG_BINS_IN_USE = 2'd3;

    // Transaction kinds.
    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic check;
        logic div_step;
        logic limit;
        logic mem_read;
        logic update;
        logic out_load;
    } hbc_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic check_ok;
        logic is_read;
        logic div_done;
        logic limit_ok;
        logic out_free;
    } hbc_status_t;

endpackage

`default_nettype wire

FILE: rtl/hbc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module hbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hbc_datapath.sv
// Datapath: configuration, bounds check, shift-subtract divider, count store and result register.
`default_nettype none

module hbc_datapath
    import hbc_pkg::*;
#(
    parameter int BINS        = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [1:0]         wr_index,
    input  wire logic [31:0]        wr_data,
    input  wire logic               kind,
    input  wire logic signed [31:0] sample,
    input  wire logic [9:0]         bin_address,
    input  wire hbc_cmd_t           cmd,
    output hbc_status_t             status,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    in_range,
    output logic [9:0]              bin_index,
    output logic [31:0]             bin_count,
    output logic [31:0]             total_entries
);

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int QW = $clog2(BINS + 1);
    localparam int DW = 32 + QW;
    localparam int SW = (QW > 1) ? $clog2(QW) : 1;
    localparam int EW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic signed [31:0]     range_start_reg;
    logic signed [31:0]     range_stop_reg;
    logic [30:0]            bin_step_reg;
    logic [10:0]            bins_in_use_reg;

    logic                   kind_reg;
    logic signed [31:0]     sample_reg;
    logic [9:0]             addr_reg;
    logic [31:0]            diff_reg;
    logic [31:0]            rem_reg;
    logic [QW-1:0]          q_reg;
    logic [SW-1:0]          step_reg;
    logic                   hit_reg;
    logic [AW-1:0]          bin_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic                   out_valid_reg;
    logic                   in_range_reg;
    logic [9:0]             bin_index_reg;
    logic [31:0]            bin_count_reg;
    logic [31:0]            total_out_reg;

    logic [31:0]            lim32;
    logic [DW-1:0]          top_trial;
    logic [DW-1:0]          trial;
    logic                   ge;
    logic                   fill_ok;
    logic                   read_ok;
    logic [31:0]            addr32;
    logic [31:0]            bin32;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [COUNT_WIDTH-1:0] new_total;
    logic [EW-1:0]          cnt_ext;
    logic [EW-1:0]          total_ext;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    // The effective bin limit is bins_in_use clipped to the store depth.
    assign lim32 = (32'(bins_in_use_reg) < 32'(BINS)) ? 32'(bins_in_use_reg) : 32'(BINS);

    // A quotient of 2^QW or more is always past the limit, so it is rejected up front.
    assign top_trial = DW'(bin_step_reg) << QW;
    assign fill_ok   = (bin_step_reg != '0) && (sample_reg > range_start_reg)
                       && (sample_reg < range_stop_reg) && (DW'(diff_reg) < top_trial);
    assign addr32    = 32'(addr_reg);
    assign read_ok   = addr32 < lim32;

    assign trial = DW'(bin_step_reg) << step_reg;
    assign ge    = DW'(rem_reg) >= trial;

    assign new_count = (rd_data == CMAX) ? rd_data : rd_data + COUNT_WIDTH'(1);
    assign new_total = (total_reg == CMAX) ? total_reg : total_reg + COUNT_WIDTH'(1);

    assign status.clear_done = clr_addr_reg == AW'(BINS - 1);
    assign status.check_ok   = (kind_reg == KIND_READ) ? read_ok : fill_ok;
    assign status.is_read    = kind_reg == KIND_READ;
    assign status.div_done   = step_reg == '0;
    assign status.limit_ok   = 32'(q_reg) < lim32;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign mem_we    = cmd.clear_step || (cmd.update && kind_reg == KIND_FILL);
    assign mem_waddr = cmd.clear_step ? clr_addr_reg : bin_reg;
    assign mem_wdata = cmd.clear_step ? '0 : new_count;

    hbc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BINS)
    ) u_counts (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (cmd.mem_read),
        .rd_addr (bin_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= 32'sd0;
            range_stop_reg  <= 32'sh4000_0000;
            bin_step_reg    <= 31'h0010_0000;
            bins_in_use_reg <= 11'd1024;
            clr_addr_reg    <= '0;
            total_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_RANGE_START: range_start_reg <= wr_data;
                    REG_RANGE_STOP:  range_stop_reg  <= wr_data;
                    REG_BIN_STEP:    bin_step_reg    <= wr_data[30:0];
                    REG_BINS_IN_USE: bins_in_use_reg <= wr_data[10:0];
                    default:         ;
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.update && kind_reg == KIND_FILL)
            begin
                total_reg <= new_total;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign bin32     = 32'(bin_reg);
    assign cnt_ext   = EW'(cnt_reg);
    assign total_ext = EW'(total_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            sample_reg <= sample;
            addr_reg   <= bin_address;
            diff_reg   <= sample - range_start_reg;
        end
        if (cmd.check)
        begin
            rem_reg  <= diff_reg;
            q_reg    <= '0;
            step_reg <= SW'(QW - 1);
            hit_reg  <= status.check_ok;
            bin_reg  <= addr32[AW-1:0];
        end
        if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - trial[31:0];
            end
            q_reg    <= (q_reg << 1) | QW'(ge);
            step_reg <= step_reg - SW'(1);
        end
        if (cmd.limit)
        begin
            hit_reg <= status.limit_ok;
            bin_reg <= q_reg[AW-1:0];
        end
        if (cmd.update)
        begin
            cnt_reg <= (kind_reg == KIND_FILL) ? new_count : rd_data;
        end
        if (cmd.out_load)
        begin
            in_range_reg  <= hit_reg;
            bin_index_reg <= hit_reg ? bin32[9:0] : 10'd0;
            bin_count_reg <= hit_reg ? cnt_ext[31:0] : 32'd0;
            total_out_reg <= total_ext[31:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign in_range      = in_range_reg;
    assign bin_index     = bin_index_reg;
    assign bin_count     = bin_count_reg;
    assign total_entries = total_out_reg;

endmodule

`default_nettype wire

FILE: rtl/hbc_ctrl.sv
// Controller state machine: clearing pass, bounds check, division steps and count update.
`default_nettype none

module hbc_ctrl
    import hbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire hbc_status_t status,
    output hbc_cmd_t         cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_DIV    = 8'b0000_1000,
        ST_LIMIT  = 8'b0001_0000,
        ST_READ   = 8'b0010_0000,
        ST_UPDATE = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } hbc_state_t;

    hbc_state_t state_reg;
    hbc_state_t state_next;

    assign in_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (!status.check_ok)
                begin
                    state_next = ST_OUT;
                end
                else if (status.is_read)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = status.limit_ok ? ST_READ : ST_OUT;
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/histogram_bin_counter_core.sv
// Top level of the equal-width histogram bin counter.
`default_nettype none

// Equal-width histogram over signed Q16.16 samples. A fill transaction (kind 0) is counted
// when range_start < sample < range_stop and floor((sample - range_start) / bin step) is
// below min(bins_in_use, BINS); a read transaction (kind 1) returns the count of bin_address.
// Every transaction gives one result, which waits in an output register. Items are handled
// one at a time: a fill in bounds runs the one-bit-per-cycle shift-subtract divider, then
// a limit check, count read and count update before its result is registered; a read skips
// the divider and limit check, and a dropped fill goes straight to the result. After reset
// a clearing pass writes zero to each of the BINS count entries, one per cycle, and no
// transaction is taken meanwhile; configuration writes are taken at any time.
module histogram_bin_counter_core
    import hbc_pkg::*;
#(
    parameter int BINS        = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [1:0]         wr_index,
    input  wire logic [31:0]        wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic signed [31:0] sample,
    input  wire logic [9:0]         bin_address,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    in_range,
    output logic [9:0]              bin_index,
    output logic [31:0]             bin_count,
    output logic [31:0]             total_entries
);

    hbc_cmd_t    cmd;
    hbc_status_t status;

    hbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    hbc_datapath #(
        .BINS        (BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .kind          (kind),
        .sample        (sample),
        .bin_address   (bin_address),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .in_range      (in_range),
        .bin_index     (bin_index),
        .bin_count     (bin_count),
        .total_entries (total_entries)
    );

    // Once a transaction is taken, the block is busy until its result is registered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a transaction is in flight");

    // A result that was not counted carries no bin and no count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_range) |-> (bin_index == 10'd0 && bin_count == 32'd0))
        else $error("uncounted result carries a bin or count");

    // A new result only appears as the controller leaves its busy states.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result appeared while controller still busy");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench of the histogram bin counter: directed table, then randomised phases.
`timescale 1ns / 1ps

module tb_top;
    import hbc_pkg::*;

    localparam int NBINS          = 1024;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int PHASE_ITEMS    = 416;
    localparam int RECONFIG_EVERY = 104;

    typedef struct packed {
        logic        in_range;
        logic [9:0]  index;
        logic [31:0] count;
        logic [31:0] total;
    } hist_res_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_op_t;

    typedef struct {
        row_op_t    op;
        logic       k;
        logic [31:0] val;
        logic [1:0] idx;
        logic       typed;
        hist_res_t  res;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               wr_en = 1'b0;
    logic [1:0]         wr_index = '0;
    logic [31:0]        wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               kind = KIND_FILL;
    logic signed [31:0] sample = '0;
    logic [9:0]         bin_address = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               in_range;
    logic [9:0]         bin_index;
    logic [31:0]        bin_count;
    logic [31:0]        total_entries;

    // Typed expectation that travels with the transaction on offer.
    logic      cur_typed = 1'b0;
    hist_res_t cur_exp = '0;

    // Predictor state and its copy of the registers.
    logic [31:0]        model_counts [NBINS];
    logic [31:0]        model_total;
    logic signed [31:0] cfg_start = 32'sd0;
    logic signed [31:0] cfg_stop = 32'sh4000_0000;
    logic [30:0]        cfg_width = 31'h10_0000;
    logic [10:0]        cfg_bins = 11'd1024;

    hist_res_t expected_results [$];
    stim_row_t dir_tab [$];
    int        error_count = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    int        hold_left = 0;
    int        idle_cycles = 0;
    longint    span_lo;
    longint    span_hi;

    histogram_bin_counter_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .sample        (sample),
        .bin_address   (bin_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .in_range      (in_range),
        .bin_index     (bin_index),
        .bin_count     (bin_count),
        .total_entries (total_entries)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic hist_res_t predict_bin(logic k, logic signed [31:0] s, logic [9:0] a);
        hist_res_t   r;
        logic [31:0] diff;
        logic [31:0] bin;
        logic [10:0] lim;
        r = '0;
        lim = (cfg_bins > NBINS) ? 11'(NBINS) : cfg_bins;
        if (k == KIND_FILL)
        begin
            if (cfg_width != 0 && s > cfg_start && s < cfg_stop)
            begin
                diff = s - cfg_start;
                bin = diff / {1'b0, cfg_width};
                if (bin < lim)
                begin
                    if (model_counts[bin] != 32'hFFFF_FFFF)
                        model_counts[bin] = model_counts[bin] + 1;
                    if (model_total != 32'hFFFF_FFFF)
                        model_total = model_total + 1;
                    r.in_range = 1'b1;
                    r.index = bin[9:0];
                    r.count = model_counts[bin];
                end
            end
        end
        else if (a < lim)
        begin
            r.in_range = 1'b1;
            r.index = a;
            r.count = model_counts[a];
        end
        r.total = model_total;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        $display("mismatch on %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
        error_count++;
    endtask

    // Checks leaving results first, then predicts for the transaction entering at this edge.
    always @(posedge clk)
    begin
        hist_res_t e;
        hist_res_t p;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 32'd0, {22'd0, bin_index});
                else
                begin
                    e = expected_results.pop_front();
                    if (in_range !== e.in_range)
                        report_mismatch("in_range", e.in_range, in_range);
                    if (bin_index !== e.index)
                        report_mismatch("bin_index", e.index, bin_index);
                    if (bin_count !== e.count)
                        report_mismatch("bin_count", e.count, bin_count);
                    if (total_entries !== e.total)
                        report_mismatch("total_entries", e.total, total_entries);
                end
            end
            if (in_valid && !in_stall)
            begin
                p = predict_bin(kind, sample, bin_address);
                expected_results.push_back(cur_typed ? cur_exp : p);
            end
        end
    end

    // Receiver: a long hold-off takes precedence over random stalls.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic stim_row_t row(row_op_t op, logic k, logic [31:0] val, logic [1:0] idx,
                                      logic typed, hist_res_t res);
        stim_row_t r;
        r.op = op;
        r.k = k;
        r.val = val;
        r.idx = idx;
        r.typed = typed;
        r.res = res;
        return r;
    endfunction

    task automatic send_item(logic k, logic [31:0] s, logic [9:0] a, logic typed,
                             hist_res_t e);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        sample <= s;
        bin_address <= a;
        cur_typed <= typed;
        cur_exp <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        case (idx)
            REG_RANGE_START: cfg_start = data;
            REG_RANGE_STOP:  cfg_stop = data;
            REG_BIN_STEP:    cfg_width = data[30:0];
            REG_BINS_IN_USE: cfg_bins = data[10:0];
            default:         ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly a well-formed range of a few bins; now and then a random stop or bin count.
    task automatic set_random_cfg();
        int unsigned nb;
        int unsigned w;
        nb = ($urandom_range(3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 16);
        case ($urandom_range(2))
            0:       w = $urandom_range(1, 64);
            1:       w = $urandom_range(1, 32'h4_0000);
            default: w = $urandom_range(1, 32'h7FFF_FFFF);
        endcase
        span_lo = longint'(int'($urandom));
        span_hi = span_lo + longint'(nb) * longint'(w);
        if (span_hi > 64'sd2147483647)
            span_hi = 64'sd2147483647;
        if ($urandom_range(9) == 0)
            span_hi = longint'(int'($urandom));
        if ($urandom_range(9) == 0)
            nb = $urandom_range(0, 2047);
        write_reg(REG_RANGE_START, 32'(span_lo));
        write_reg(REG_RANGE_STOP, 32'(span_hi));
        write_reg(REG_BIN_STEP, w);
        write_reg(REG_BINS_IN_USE, nb);
    endtask

    task automatic run_phase(int n);
        logic [31:0]     s;
        logic [9:0]      a;
        logic            k;
        longint unsigned r;
        for (int i = 0; i < n; i++)
        begin
            if (i % RECONFIG_EVERY == 0)
            begin
                drain_results();
                set_random_cfg();
            end
            r = {$urandom, $urandom};
            case ($urandom_range(9))
                0:       s = $urandom;
                1:       s = 32'(((r & 1) != 0 ? span_hi : span_lo) + longint'((r >> 1) % 3) - 1);
                default: s = (span_hi >= span_lo) ?
                             32'(span_lo + longint'(r % longint'(span_hi - span_lo + 1))) :
                             $urandom;
            endcase
            k = ($urandom_range(9) < 3) ? KIND_READ : KIND_FILL;
            a = $urandom_range(1) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 15));
            send_item(k, s, a, 1'b0, '0);
        end
    endtask

    initial
    begin
        for (int i = 0; i < NBINS; i++)
            model_counts[i] = '0;
        model_total = '0;

        dir_tab.push_back(row(ROW_ITEM, KIND_READ, 32'd0, 2'd0, 1'b1, {1'b1, 10'd0, 32'd0, 32'd0}));
        dir_tab.push_back(row(ROW_ITEM, KIND_READ, 32'd1023, 2'd0, 1'b1,
                              {1'b1, 10'd1023, 32'd0, 32'd0}));
        // Samples on either bound are excluded, as are the signed extremes.
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h0, 2'd0, 1'b1, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h4000_0000, 2'd0, 1'b1, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h7FFF_FFFF, 2'd0, 1'b1, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h8000_0000, 2'd0, 1'b1, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h1, 2'd0, 1'b1, {1'b1, 10'd0, 32'd1, 32'd1}));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h3FFF_FFFF, 2'd0, 1'b1,
                              {1'b1, 10'd1023, 32'd1, 32'd2}));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h10_0000, 2'd0, 1'b1,
                              {1'b1, 10'd1, 32'd1, 32'd3}));
        dir_tab.push_back(row(ROW_ITEM, KIND_READ, 32'd0, 2'd0, 1'b1, {1'b1, 10'd0, 32'd1, 32'd3}));
        // No bins in use: everything is invalid.
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'd0, REG_BINS_IN_USE, 1'b0, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_READ, 32'd0, 2'd0, 1'b1, {1'b0, 10'd0, 32'd0, 32'd3}));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h1, 2'd0, 1'b1, {1'b0, 10'd0, 32'd0, 32'd3}));
        // A bin count beyond the store acts as the full store.
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'd2000, REG_BINS_IN_USE, 1'b0, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_READ, 32'd1023, 2'd0, 1'b1,
                              {1'b1, 10'd1023, 32'd1, 32'd3}));
        // Stale counts above a lowered bin count read as invalid.
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'd2, REG_BINS_IN_USE, 1'b0, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_READ, 32'd1023, 2'd0, 1'b1,
                              {1'b0, 10'd0, 32'd0, 32'd3}));
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'd1024, REG_BINS_IN_USE, 1'b0, '0));
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'd0, REG_BIN_STEP, 1'b0, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'd5, 2'd0, 1'b1, {1'b0, 10'd0, 32'd0, 32'd3}));
        // Inverted range counts nothing.
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'h7FFF_FFFF, REG_BIN_STEP, 1'b0, '0));
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'd100, REG_RANGE_START, 1'b0, '0));
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'd50, REG_RANGE_STOP, 1'b0, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'd75, 2'd0, 1'b1, {1'b0, 10'd0, 32'd0, 32'd3}));
        // Widest range with the widest bins.
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'h8000_0000, REG_RANGE_START, 1'b0, '0));
        dir_tab.push_back(row(ROW_WRITE, KIND_FILL, 32'h7FFF_FFFF, REG_RANGE_STOP, 1'b0, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h0, 2'd0, 1'b0, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_FILL, 32'h7FFF_FFFE, 2'd0, 1'b0, '0));
        dir_tab.push_back(row(ROW_ITEM, KIND_READ, 32'd2, 2'd0, 1'b0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].op == ROW_WRITE)
            begin
                drain_results();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end
            else
                send_item(dir_tab[i].k, dir_tab[i].val, dir_tab[i].val[9:0],
                          dir_tab[i].typed, dir_tab[i].res);
        end

        send_idle = 6;
        recv_idle = 88;
        run_phase(PHASE_ITEMS);
        send_idle = 88;
        recv_idle = 6;
        run_phase(PHASE_ITEMS);
        // The sender waits for every result, then the receiver holds off while the sender is stalled.
        drain_results();
        send_idle = 0;
        recv_idle = 0;
        hold_left = 400;
        run_phase(PHASE_ITEMS);

        drain_results();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
